[rtl/ose_pkg.sv]
// Shared types and codes for the ordered set engine.
`timescale 1ns / 1ps
`default_nettype none

package ose_pkg;

  // Fixed widths of the channel fields.
  localparam int KIND_W  = 3;
  localparam int KEY_W   = 32;
  localparam int POS_W   = 5;
  localparam int RANK_W  = 6;

  // Operation codes carried by the kind field.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_ERASE  = 3'd1,
    KIND_COUNT  = 3'd2,
    KIND_LOWER  = 3'd3,
    KIND_UPPER  = 3'd4,
    KIND_CLEAR  = 3'd5,
    KIND_READ   = 3'd6
  } kind_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic compare;
    logic insert;
    logic erase;
    logic clear;
  } cell_cmd_t;

  // Status a cell shows to its neighbors and to the top level.
  typedef struct packed {
    logic valid;
    logic lt;
    logic le;
    logic eq;
  } cell_flags_t;

endpackage

`default_nettype wire

[rtl/ose_in_if.sv]
// Request channel: one operation per beat.
`timescale 1ns / 1ps
`default_nettype none

interface ose_in_if;
  import ose_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [KEY_W-1:0]  key;
  logic [POS_W-1:0]         position;

  modport source (output valid, output kind, output key, output position, input ready);
  modport sink   (input valid, input kind, input key, input position, output ready);
endinterface

`default_nettype wire

[rtl/ose_out_if.sv]
// Response channel: one result per beat.
`timescale 1ns / 1ps
`default_nettype none

interface ose_out_if;
  import ose_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [RANK_W-1:0]        rank;
  logic signed [KEY_W-1:0]  stored_value;
  logic [RANK_W-1:0]        set_size;
  logic                     full_reject;

  modport source (output valid, output found, output rank, output stored_value,
                  output set_size, output full_reject, input ready);
  modport sink   (input valid, input found, input rank, input stored_value,
                  input set_size, input full_reject, output ready);
endinterface

`default_nettype wire

[rtl/ose_cell.sv]
// One storage cell of the sorted chain: a key, its valid bit and compare flags.
`timescale 1ns / 1ps
`default_nettype none

module ose_cell #(
  parameter int KEY_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ose_pkg::cell_cmd_t          cmd,
  input  wire logic signed [KEY_BITS-1:0]  op_key,
  input  wire logic signed [KEY_BITS-1:0]  left_key,
  input  wire ose_pkg::cell_flags_t        left_flags,
  input  wire logic signed [KEY_BITS-1:0]  right_key,
  input  wire ose_pkg::cell_flags_t        right_flags,
  output      logic signed [KEY_BITS-1:0]  key,
  output      ose_pkg::cell_flags_t        flags
);
  import ose_pkg::*;

  logic valid;
  logic lt;
  logic le;
  logic eq;

  // Valid bit shifts with the keys; the chain stays a run of ones from cell zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.insert) begin
      valid <= left_flags.valid;
    end else if (cmd.erase) begin
      valid <= right_flags.valid;
    end
  end

  // Compare flags against the operand; an empty cell counts as not below it.
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      lt <= valid && (key < op_key);
      le <= valid && (key <= op_key);
      eq <= valid && (key == op_key);
    end
  end

  // Insert moves keys one cell right from the insertion point, erase one cell left.
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (!left_flags.lt) begin
        key <= left_key;
      end else if (!lt) begin
        key <= op_key;
      end
    end else if (cmd.erase) begin
      if (!lt) begin
        key <= right_key;
      end
    end
  end

  assign flags = '{valid: valid, lt: lt, le: le, eq: eq};

endmodule

`default_nettype wire

[rtl/ordered_set_engine_core.sv]
// Each request passes through the accept, compare and execute steps before its response is registered.
// A new request is accepted only in the idle step, so operations do not overlap; the execute step
// waits while a previous response is still held in the output register.
// Every cell compares in parallel, so the step sequence does not depend on the set size.
// Reset empties the set at once; key storage itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ordered_set_engine_core #(
  parameter int CAPACITY = 32,
  parameter int KEY_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ose_in_if.sink      req,
  ose_out_if.source   rsp
);
  import ose_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  state_t state;
  state_t state_next;

  kind_t                      op_kind;
  logic signed [KEY_BITS-1:0] op_key;
  logic [POS_W-1:0]           op_pos;
  logic signed [KEY_BITS-1:0] key_ext;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  cell_cmd_t   cmd;
  logic        exec_fire;
  logic        out_free;

  logic signed [KEY_BITS-1:0] cell_key   [CAPACITY];
  cell_flags_t                cell_flags [CAPACITY];

  logic [CAPACITY-1:0] vld_vec;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] le_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] lt_edge;
  logic [CAPACITY-1:0] le_edge;
  logic [CAPACITY-1:0] pos_hit;
  logic [CAPACITY-1:0] sel;

  logic [CW-1:0] rank_lt;
  logic [CW-1:0] rank_le;
  logic          present;
  logic          full_now;
  logic          pos_ok;
  logic          do_insert;
  logic          do_erase;
  logic          do_clear;

  logic signed [KEY_BITS-1:0] sel_key;
  logic signed [KEY_W-1:0]    sel_value;
  logic                       res_found;
  logic [CW-1:0]              res_rank;
  logic                       res_full;

  // Key operand: low KEY_BITS bits taken as two's complement, or the
  // whole field zero-extended when keys are wider than the field.
  generate
    if (KEY_BITS <= KEY_W) begin : g_key_narrow
      assign key_ext = req.key[KEY_BITS-1:0];
    end else begin : g_key_wide
      assign key_ext = {{(KEY_BITS-KEY_W){1'b0}}, req.key};
    end
  endgenerate

  // Operation register loaded on each request beat.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_kind <= kind_t'(req.kind);
      op_key  <= key_ext;
      op_pos  <= req.position;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req.ready   = 1'b0;
    exec_fire   = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
      end
      ST_EXEC: begin
        exec_fire  = out_free;
        cmd.insert = out_free && do_insert;
        cmd.erase  = out_free && do_erase;
        cmd.clear  = out_free && do_clear;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign out_free = !rsp.valid || rsp.ready;

  // The chain of cells; the ends see a fixed "below everything" left edge
  // and an empty right edge.
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_BITS-1:0] lkey;
      logic signed [KEY_BITS-1:0] rkey;
      cell_flags_t                lflags;
      cell_flags_t                rflags;

      if (i == 0) begin : g_left_end
        assign lkey   = op_key;
        assign lflags = '{valid: 1'b1, lt: 1'b1, le: 1'b1, eq: 1'b0};
      end else begin : g_left
        assign lkey   = cell_key[i-1];
        assign lflags = cell_flags[i-1];
      end

      if (i == CAPACITY - 1) begin : g_right_end
        assign rkey   = op_key;
        assign rflags = '0;
      end else begin : g_right
        assign rkey   = cell_key[i+1];
        assign rflags = cell_flags[i+1];
      end

      ose_cell #(
        .KEY_BITS (KEY_BITS)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .op_key      (op_key),
        .left_key    (lkey),
        .left_flags  (lflags),
        .right_key   (rkey),
        .right_flags (rflags),
        .key         (cell_key[i]),
        .flags       (cell_flags[i])
      );

      assign vld_vec[i] = cell_flags[i].valid;
      assign lt_vec[i]  = cell_flags[i].lt;
      assign le_vec[i]  = cell_flags[i].le;
      assign eq_vec[i]  = cell_flags[i].eq;
      assign pos_hit[i] = (PW'(i) == PW'(op_pos));

      if (i == 0) begin : g_edge0
        assign lt_edge[i] = !lt_vec[i];
        assign le_edge[i] = !le_vec[i];
      end else begin : g_edge
        assign lt_edge[i] = lt_vec[i-1] && !lt_vec[i];
        assign le_edge[i] = le_vec[i-1] && !le_vec[i];
      end
    end
  endgenerate

  // Flags form a run of ones from cell zero; the end of the run is the rank.
  always_comb begin
    rank_lt = '0;
    rank_le = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lt_edge[i]) rank_lt = rank_lt | CW'(i);
      if (le_edge[i]) rank_le = rank_le | CW'(i);
    end
    if (lt_vec[CAPACITY-1]) rank_lt = CW'(CAPACITY);
    if (le_vec[CAPACITY-1]) rank_le = CW'(CAPACITY);
  end

  assign present  = |eq_vec;
  assign full_now = (count == CW'(CAPACITY));
  assign pos_ok   = (PW'(op_pos) < PW'(count));

  assign do_insert = (op_kind == KIND_INSERT) && !present && !full_now;
  assign do_erase  = (op_kind == KIND_ERASE) && present;
  assign do_clear  = (op_kind == KIND_CLEAR);

  // One-hot cell select for the value readout.
  always_comb begin
    case (op_kind)
      KIND_LOWER: sel = lt_edge & vld_vec;
      KIND_UPPER: sel = le_edge & vld_vec;
      KIND_READ:  sel = pos_hit & vld_vec;
      default:    sel = '0;
    endcase
  end

  // AND-OR readout of the selected cell.
  always_comb begin
    sel_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel[i]) sel_key = sel_key | cell_key[i];
    end
  end

  generate
    if (KEY_BITS >= KEY_W) begin : g_val_trunc
      assign sel_value = sel_key[KEY_W-1:0];
    end else begin : g_val_sext
      assign sel_value = {{(KEY_W-KEY_BITS){sel_key[KEY_BITS-1]}}, sel_key};
    end
  endgenerate

  // Result fields and the set size after the operation.
  always_comb begin
    res_found  = 1'b0;
    res_rank   = '0;
    res_full   = 1'b0;
    count_next = count;
    case (op_kind)
      KIND_INSERT: begin
        res_found = do_insert;
        res_full  = !present && full_now;
        if (do_insert) count_next = count + CW'(1);
      end
      KIND_ERASE: begin
        res_found = present;
        if (present) count_next = count - CW'(1);
      end
      KIND_COUNT: begin
        res_found = present;
      end
      KIND_LOWER: begin
        res_found = |sel;
        res_rank  = rank_lt;
      end
      KIND_UPPER: begin
        res_found = |sel;
        res_rank  = rank_le;
      end
      KIND_CLEAR: begin
        res_found  = (count != '0);
        count_next = '0;
      end
      KIND_READ: begin
        res_found = pos_ok;
        res_rank  = pos_ok ? CW'(op_pos) : count;
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  // Held-key count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec_fire) begin
      count <= count_next;
    end
  end

  // Output register: holds a finished result until its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (exec_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      rsp.found        <= res_found;
      rsp.rank         <= RANK_W'(res_rank);
      rsp.stored_value <= sel_value;
      rsp.set_size     <= RANK_W'(count_next);
      rsp.full_reject  <= res_full;
    end
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("held-key count above capacity");

  // The valid bits of the chain agree with the count.
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(vld_vec) == int'(count))
    else $error("cell valid bits disagree with count");

  // A completed insert grows the set by exactly one key.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the set by one");

  // The result register is loaded only from the execute step.
  a_exec_state: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_EXEC)
    else $error("response raised outside the execute step");

endmodule

`default_nettype wire
